// File: hw/rtl/api_pkg.sv
// api_pkg: shared constants, codes and the CORDIC arctangent table for the
// arc point interpolator. No dependencies; used by every api_* module.
package api_pkg;

  // Step register
  localparam int unsigned STEP_W = 14;
  localparam logic [STEP_W-1:0] STEP_RESET = 14'd364;

  // Action codes of an input request
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_NEXT = 1'b1;

  // CORDIC start value: gain 0.60725293 in Q30
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  // Radius is multiplied in chunks of this many bits
  localparam int unsigned CHUNK_W = 24;

  // Rounding constant for the Q30 scale: one half
  localparam int unsigned ROUND_BIT = 29;

  // Two-entry queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // atan(2^-i) in units of 2^-32 turn, truncated
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051D;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2E;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2F9;
      5'd15: val = 32'h0000517C;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A2F;
      5'd19: val = 32'h00000517;
      5'd20: val = 32'h0000028B;
      5'd21: val = 32'h00000145;
      5'd22: val = 32'h000000A2;
      5'd23: val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/api_queue.sv
// api_queue: two-entry show-ahead job queue between front and back.
// Depends on api_pkg for the queue depth.
module api_queue #(
  parameter int unsigned DATA_W = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int unsigned CNT_W = $clog2(api_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(api_pkg::QUEUE_DEPTH);

  logic [DATA_W-1:0] mem_r [api_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(api_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(api_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(api_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push && !full, pop && !empty})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/api_front.sv
// api_front: takes input requests, holds the loaded arc and the angle walk,
// and queues one point job per next request on an active arc. Depends on api_pkg.
module api_front #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned JOB_W      = 1 + ANGLE_BITS + 3 * COORD_BITS - 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [COORD_BITS-2:0]         in_radius,
  input  logic [ANGLE_BITS-1:0]         in_start_angle,
  input  logic [ANGLE_BITS-1:0]         in_end_angle,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [api_pkg::STEP_W-1:0]    cfg_data,
  output logic                          job_push,
  output logic [JOB_W-1:0]              job_data,
  input  logic                          job_full
);

  localparam int unsigned FIN_W = ANGLE_BITS + 1;
  localparam int unsigned CUR_W = ((FIN_W > api_pkg::STEP_W) ? FIN_W : api_pkg::STEP_W) + 1;

  logic [api_pkg::STEP_W-1:0]   step_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [COORD_BITS-2:0]        radius_r;
  logic [CUR_W-1:0]             cur_r, cur_nxt;
  logic [FIN_W-1:0]             fin_r, fin_nxt;
  logic                         active_r, active_nxt;

  logic                         accept;
  logic                         load;
  logic                         more;
  logic [api_pkg::STEP_W-1:0]   step_eff;
  logic [ANGLE_BITS-1:0]        job_angle;

  assign in_ready  = !job_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign load      = accept && (in_action == api_pkg::ACTION_LOAD);
  assign more      = (cur_r < CUR_W'(fin_r));
  assign step_eff  = (step_r == '0) ? api_pkg::STEP_W'(1) : step_r;
  assign job_push  = accept && (in_action == api_pkg::ACTION_NEXT) && active_r;
  assign job_angle = more ? cur_r[ANGLE_BITS-1:0] : fin_r[ANGLE_BITS-1:0];
  assign job_data  = {!more, job_angle, radius_r, cy_r, cx_r};

  always_comb begin
    cur_nxt    = cur_r;
    fin_nxt    = fin_r;
    active_nxt = active_r;
    if (load) begin
      cur_nxt    = CUR_W'(in_start_angle);
      fin_nxt    = FIN_W'(in_end_angle) +
                   ((in_start_angle > in_end_angle) ? (FIN_W'(1) << ANGLE_BITS) : '0);
      active_nxt = 1'b1;
    end else if (job_push) begin
      if (more) begin
        cur_nxt = cur_r + CUR_W'(step_eff);
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= api_pkg::STEP_RESET;
      cur_r    <= '0;
      fin_r    <= '0;
      active_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
      cur_r    <= cur_nxt;
      fin_r    <= fin_nxt;
      active_r <= active_nxt;
    end
  end

  // Arc geometry: payload only
  always_ff @(posedge clk) begin
    if (load) begin
      cx_r     <= in_center_x;
      cy_r     <= in_center_y;
      radius_r <= in_radius;
    end
  end

endmodule

// File: hw/rtl/api_back.sv
// api_back: point unit. Iterative CORDIC, chunked radius multiply, center add
// with saturation, and the result register. Depends on api_pkg.
module api_back #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned COORD_BITS   = 32,
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned JOB_W        = 1 + ANGLE_BITS + 3 * COORD_BITS - 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_empty,
  input  logic [JOB_W-1:0]             job_data,
  output logic                         job_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last_point
);

  localparam int unsigned RAD_W  = COORD_BITS - 1;
  localparam int unsigned NCHUNK = (RAD_W + api_pkg::CHUNK_W - 1) / api_pkg::CHUNK_W;
  localparam int unsigned RPAD_W = NCHUNK * api_pkg::CHUNK_W;
  localparam int unsigned ACC_W  = RPAD_W + 32;
  localparam int unsigned PROD_W = api_pkg::CHUNK_W + 32;
  localparam int unsigned CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned ITER_W = $clog2(CORDIC_STEPS);
  localparam int unsigned SUM_W  = COORD_BITS + 2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROT  = 6'b000010,
    ST_MAP  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_FIN  = 6'b100000
  } bstate_t;

  bstate_t                      state_r;
  logic [ITER_W-1:0]            iter_r;
  logic [CHK_W-1:0]             chunk_r;
  logic                         sel_y_r;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [RPAD_W-1:0]            rpad_r;
  logic [1:0]                   quad_r;
  logic                         last_r;
  logic signed [31:0]           x_r, y_r;
  logic signed [33:0]           z_r;
  logic [31:0]                  mag_x_r, mag_y_r;
  logic                         neg_x_r, neg_y_r;
  logic [ACC_W-1:0]             acc_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;

  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         out_last_r;

  // Job fields
  logic signed [COORD_BITS-1:0] j_cx, j_cy;
  logic [RAD_W-1:0]             j_radius;
  logic [ANGLE_BITS-1:0]        j_angle;
  logic                         j_last;
  logic signed [33:0]           z_init;

  // Datapath wires
  logic signed [31:0]           dx, dy;
  logic signed [33:0]           at;
  logic signed [32:0]           trig_c, trig_s;
  logic [31:0]                  mag_sel;
  logic [PROD_W-1:0]            prod;
  logic [COORD_BITS-1:0]        mag;
  logic signed [SUM_W-1:0]      off, sum;
  logic signed [COORD_BITS-1:0] center_sel, sat_val;
  logic                         out_free;

  assign j_cx     = job_data[COORD_BITS-1:0];
  assign j_cy     = job_data[2*COORD_BITS-1:COORD_BITS];
  assign j_radius = job_data[3*COORD_BITS-2:2*COORD_BITS];
  assign j_angle  = job_data[3*COORD_BITS-2+ANGLE_BITS:3*COORD_BITS-1];
  assign j_last   = job_data[JOB_W-1];
  assign z_init   = 34'(j_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);

  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign out_free = !out_valid_r || out_ready;

  // Rotation step: take z >= 0 as a positive rotation
  assign dx = y_r >>> iter_r;
  assign dy = x_r >>> iter_r;
  assign at = 34'(api_pkg::atan_turn(5'(iter_r)));

  // Quadrant fold
  always_comb begin
    case (quad_r)
      2'd0:    begin trig_c = 33'(x_r);  trig_s = 33'(y_r);  end
      2'd1:    begin trig_c = -33'(y_r); trig_s = 33'(x_r);  end
      2'd2:    begin trig_c = -33'(x_r); trig_s = -33'(y_r); end
      default: begin trig_c = 33'(y_r);  trig_s = -33'(x_r); end
    endcase
  end

  // One chunk of radius times trig magnitude
  assign mag_sel = sel_y_r ? mag_y_r : mag_x_r;
  assign prod    = PROD_W'(rpad_r[chunk_r*api_pkg::CHUNK_W +: api_pkg::CHUNK_W]) *
                   PROD_W'(mag_sel);

  // Rounded offset plus center, saturated
  assign mag        = acc_r[30 +: COORD_BITS];
  assign off        = (sel_y_r ? neg_y_r : neg_x_r) ? -$signed({2'b00, mag})
                                                    :  $signed({2'b00, mag});
  assign center_sel = sel_y_r ? cy_r : cx_r;
  assign sum        = SUM_W'(center_sel) + off;

  always_comb begin
    if (sum[SUM_W-1:COORD_BITS-1] == '0 || sum[SUM_W-1:COORD_BITS-1] == '1) begin
      sat_val = sum[COORD_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_val = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      chunk_r     <= '0;
      sel_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished point, or drop the one just taken
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            iter_r  <= '0;
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_MAP;
          end else begin
            iter_r <= iter_r + 1'b1;
          end
        end
        ST_MAP: begin
          chunk_r <= '0;
          sel_y_r <= 1'b0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (chunk_r == CHK_W'(NCHUNK - 1)) begin
            state_r <= ST_ADD;
          end else begin
            chunk_r <= chunk_r + 1'b1;
          end
        end
        ST_ADD: begin
          chunk_r <= '0;
          if (sel_y_r) begin
            state_r <= ST_FIN;
          end else begin
            sel_y_r <= 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r   <= j_cx;
        cy_r   <= j_cy;
        rpad_r <= RPAD_W'(j_radius);
        quad_r <= j_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        last_r <= j_last;
        x_r    <= api_pkg::GAIN_Q30;
        y_r    <= '0;
        z_r    <= z_init;
      end
      ST_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
      end
      ST_MAP: begin
        neg_x_r <= trig_c[32];
        neg_y_r <= trig_s[32];
        mag_x_r <= trig_c[32] ? 32'(-trig_c) : 32'(trig_c);
        mag_y_r <= trig_s[32] ? 32'(-trig_s) : 32'(trig_s);
        acc_r   <= ACC_W'(1) << api_pkg::ROUND_BIT;
      end
      ST_MUL: begin
        acc_r <= acc_r + (ACC_W'(prod) << (chunk_r * api_pkg::CHUNK_W));
      end
      ST_ADD: begin
        if (sel_y_r) begin
          py_r <= sat_val;
        end else begin
          px_r <= sat_val;
        end
        acc_r <= ACC_W'(1) << api_pkg::ROUND_BIT;
      end
      ST_FIN: begin
        if (out_free) begin
          out_x_r    <= px_r;
          out_y_r    <= py_r;
          out_last_r <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;

endmodule

// File: hw/rtl/arc_point_interpolator.sv
// arc_point_interpolator: top level of the arc tessellator. Front end,
// job queue and point unit. Depends on api_pkg, api_front, api_queue, api_back.
//
//   channel   | ports                                    | direction
//   ----------+------------------------------------------+-----------
//   input     | in_valid/in_ready, in_action, in_center_x,| in
//             | in_center_y, in_radius, in_start_angle,  |
//             | in_end_angle                             |
//   result    | out_valid/out_ready, out_point_x,        | out
//             | out_point_y, out_last_point              |
//   config    | cfg_valid/cfg_ready, cfg_data (step)     | in
//
// A load request yields no point. A next request on a loaded arc is queued as
// one point job. The point unit takes one job at a time through rotation, a
// chunked multiply and center add for x then y (NCHUNK = radius width / 24
// rounded up) and the result register, one CORDIC step per cycle in rotation.
// Reset (rst_n low, synchronous) drops any loaded arc and restores the
// 364-unit step. The front stalls in_ready only when the two-entry queue is
// full; the point unit holds a finished point until the output register frees.
module arc_point_interpolator #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned COORD_BITS   = 32,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [COORD_BITS-2:0]        in_radius,
  input  logic [ANGLE_BITS-1:0]        in_start_angle,
  input  logic [ANGLE_BITS-1:0]        in_end_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last_point,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [api_pkg::STEP_W-1:0]   cfg_data
);

  // Job word: {last, angle, radius, center_y, center_x}
  localparam int unsigned JOB_W = 1 + ANGLE_BITS + 3 * COORD_BITS - 1;

  logic             job_push;
  logic [JOB_W-1:0] job_in;
  logic             job_full;
  logic             job_pop;
  logic [JOB_W-1:0] job_out;
  logic             job_empty;

  // Front: classify requests, walk the angle, queue point jobs
  api_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_start_angle (in_start_angle),
    .in_end_angle   (in_end_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .job_push       (job_push),
    .job_data       (job_in),
    .job_full       (job_full)
  );

  // Decouple front and point unit
  api_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  // Back: compute and deliver each point
  api_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job_data       (job_out),
    .job_pop        (job_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

endmodule
